// ===== rtl/ascii_motor_command_parser_assert.svh =====
// ----------------------------------------------------------------------------
// ascii_motor_command_parser_assert
// Assertion macros for the RTL files of the motor command parser.
// Each macro expects signals named clk and rst in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef ASCII_MOTOR_COMMAND_PARSER_ASSERT_SVH
`define ASCII_MOTOR_COMMAND_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define AMCP_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define AMCP_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== rtl/amcp_pkg.sv =====
// ----------------------------------------------------------------------------
// amcp_pkg
// Types and constants of the ASCII motor command parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

  localparam int LINE_MAX = 63;
  localparam int MOTORS   = 3;
  localparam int COUNT_W  = $clog2(LINE_MAX + 1);
  localparam int OUT_W    = 48;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [3:0] {
    ACT_PING       = 4'd0,
    ACT_STATUS     = 4'd1,
    ACT_DISABLE_ALL = 4'd2,
    ACT_DEBUG      = 4'd3,
    ACT_ENABLE     = 4'd4,
    ACT_DISABLE    = 4'd5,
    ACT_DUTY       = 4'd6,
    ACT_DIR        = 4'd7,
    ACT_CLEAR_FAULT = 4'd8,
    ACT_ZERO_COUNT = 4'd9,
    ACT_BAD_INDEX  = 4'd10,
    ACT_NO_COMMA   = 4'd11,
    ACT_UNKNOWN    = 4'd12
  } action_t;

  typedef enum logic [2:0] {
    NUM_SKIP   = 3'b001,
    NUM_ACTIVE = 3'b010,
    NUM_DONE   = 3'b100
  } num_phase_t;

  // Line context handed to the decoder.
  typedef struct packed {
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic [7:0]  third_char;
    logic        comma_seen;
    logic        number_negative;
    logic [31:0] number_accum;
  } line_ctx_t;

  // Result item; action sits in the lowest bits.
  typedef struct packed {
    logic        reverse;
    logic [31:0] value;
    logic [3:0]  motor_index;
    action_t     action;
  } result_t;

endpackage

// ===== rtl/amcp_decode.sv =====
// ----------------------------------------------------------------------------
// amcp_decode
// Turns the collected line context into one command result.
// ----------------------------------------------------------------------------
module amcp_decode
  import amcp_pkg::*;
(
  input  line_ctx_t ctx,
  output result_t   result
);

  logic [31:0] num;
  logic [7:0]  idx;

  always_comb begin
    num = ctx.number_negative ? (32'd0 - ctx.number_accum) : ctx.number_accum;
    // Index wraps modulo 256, so anything below '0' lands far above MOTORS.
    idx = ctx.second_char - CH_ZERO;

    result.action      = ACT_UNKNOWN;
    result.motor_index = 4'd0;
    result.value       = 32'd0;
    result.reverse     = 1'b0;

    if (ctx.first_char == CH_P && ctx.second_char == CH_NUL) begin
      result.action = ACT_PING;
    end else if (ctx.first_char == CH_QUERY) begin
      result.action = ACT_STATUS;
    end else if (ctx.first_char == CH_D && ctx.second_char == CH_A) begin
      result.action = ACT_DISABLE_ALL;
    end else if (ctx.first_char == CH_D && ctx.second_char == CH_B &&
                 ctx.third_char == CH_G) begin
      result.action = ACT_DEBUG;
    end else if (idx >= 8'(MOTORS)) begin
      result.action = ACT_BAD_INDEX;
    end else begin
      result.motor_index = idx[3:0];
      case (ctx.first_char)
        CH_E: result.action = ACT_ENABLE;
        CH_D: result.action = ACT_DISABLE;
        CH_S: begin
          if (ctx.comma_seen) begin
            result.action = ACT_DUTY;
            result.value  = num;
          end else begin
            result.action = ACT_NO_COMMA;
          end
        end
        CH_R: begin
          if (ctx.comma_seen) begin
            result.action  = ACT_DIR;
            result.value   = num;
            result.reverse = (num != 32'd0);
          end else begin
            result.action = ACT_NO_COMMA;
          end
        end
        CH_C: result.action = ACT_CLEAR_FAULT;
        CH_Z: result.action = ACT_ZERO_COUNT;
        default: begin
          result.action      = ACT_UNKNOWN;
          result.motor_index = 4'd0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/amcp_out_buf.sv =====
// ----------------------------------------------------------------------------
// amcp_out_buf
// Output register with one skid entry between decoder and result stream.
// ----------------------------------------------------------------------------
`include "ascii_motor_command_parser_assert.svh"

module amcp_out_buf
  import amcp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_item,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  logic    skid_valid;
  result_t skid_item;
  logic    out_stall;

  assign out_stall = out_valid && !out_ready;
  assign in_ready  = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_stall) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_stall) begin
      if (push) begin
        skid_item <= push_item;
      end
    end else if (skid_valid) begin
      out_item <= skid_item;
    end else if (push) begin
      out_item <= push_item;
    end
  end

  `AMCP_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid,
                   "skid entry full while output register is empty")
  `AMCP_ASSERT_IMP(a_no_push_when_full, push, !skid_valid,
                   "result pushed while both entries are full")
  `AMCP_ASSERT_NXT(a_stalled_push_kept, push && out_stall, skid_valid,
                   "result pushed during a stall was not kept")
  `AMCP_ASSERT_NXT(a_skid_drains, skid_valid && out_ready, out_valid && !skid_valid,
                   "skid entry did not move to the output register")

endmodule

// ===== rtl/ascii_motor_command_parser.sv =====
// Output: the CR or LF transaction that ends a non-empty line pushes its result
// into the output register and skid entry, a two-entry buffer that absorbs stalls.
// Throughput: one byte per cycle while s_tready is high; it drops while the skid
// entry is full. The byte parser and multiply-by-ten accumulate are combinational.
// Reset: rst clears the line state and empties the output buffer.
// ----------------------------------------------------------------------------
// ascii_motor_command_parser
// Collects received bytes into lines and decodes one motor command per line.
// ----------------------------------------------------------------------------
module ascii_motor_command_parser
  import amcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // [3:0] action, [7:4] motor_index,
                                      // [39:8] value, [40] reverse
);

  logic [COUNT_W-1:0] line_count, line_count_next;
  logic               text_ended, text_ended_next;
  num_phase_t         number_phase, number_phase_next;
  line_ctx_t          ctx, ctx_next;

  logic       accept;
  logic [7:0] b;
  logic       is_eol;
  logic       is_digit;
  logic       is_space;
  logic       emit;
  logic [31:0] accum_step;
  result_t    decoded;
  result_t    out_item;

  assign accept = s_tvalid && s_tready;
  assign b      = s_tdata;
  assign is_eol = (b == CH_LF) || (b == CH_CR);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  assign emit   = accept && is_eol && (line_count != '0);
  assign accum_step = (ctx.number_accum << 3) + (ctx.number_accum << 1) +
                      {28'd0, b[3:0]};

  always_comb begin
    line_count_next   = line_count;
    text_ended_next   = text_ended;
    number_phase_next = number_phase;
    ctx_next          = ctx;
    if (accept) begin
      if (is_eol) begin
        if (line_count != '0) begin
          line_count_next   = '0;
          text_ended_next   = 1'b0;
          number_phase_next = NUM_SKIP;
          ctx_next          = '0;
        end
      end else if (line_count < COUNT_W'(LINE_MAX)) begin
        line_count_next = line_count + COUNT_W'(1);
        if (line_count == COUNT_W'(0)) begin
          ctx_next.first_char = b;
        end else if (line_count == COUNT_W'(1)) begin
          ctx_next.second_char = b;
        end else if (line_count == COUNT_W'(2)) begin
          ctx_next.third_char = b;
        end
        // From the third byte on, look for the comma and then the number.
        if (line_count >= COUNT_W'(2) && !text_ended) begin
          if (b == CH_NUL) begin
            text_ended_next = 1'b1;
          end else if (!ctx.comma_seen) begin
            if (b == CH_COMMA) begin
              ctx_next.comma_seen = 1'b1;
            end
          end else begin
            case (number_phase)
              NUM_SKIP: begin
                if (is_space) begin
                  number_phase_next = NUM_SKIP;
                end else if (b == CH_PLUS || b == CH_MINUS) begin
                  ctx_next.number_negative = (b == CH_MINUS);
                  number_phase_next        = NUM_ACTIVE;
                end else if (is_digit) begin
                  ctx_next.number_accum = accum_step;
                  number_phase_next     = NUM_ACTIVE;
                end else begin
                  number_phase_next = NUM_DONE;
                end
              end
              NUM_ACTIVE: begin
                if (is_digit) begin
                  ctx_next.number_accum = accum_step;
                end else begin
                  number_phase_next = NUM_DONE;
                end
              end
              NUM_DONE: number_phase_next = NUM_DONE;
              default:  number_phase_next = NUM_DONE;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= '0;
      text_ended   <= 1'b0;
      number_phase <= NUM_SKIP;
      ctx          <= '0;
    end else begin
      line_count   <= line_count_next;
      text_ended   <= text_ended_next;
      number_phase <= number_phase_next;
      ctx          <= ctx_next;
    end
  end

  amcp_decode u_decode (
    .ctx    (ctx),
    .result (decoded)
  );

  amcp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_item (decoded),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, out_item};

endmodule

// ===== dv/command_checker.sv =====
// ----------------------------------------------------------------------------
// command_checker
// Watches both stream channels of the motor command parser. It follows every
// accepted byte with its own line parser, queues the command that each
// completed line decodes to, and compares every result transaction field by
// field with the oldest queued command.
// ----------------------------------------------------------------------------
module command_checker
  import amcp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] rx_byte
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // [3:0] action, [7:4] motor_index,
                                      // [39:8] value, [40] reverse
  output int               mismatches,
  output int               outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // Line state of the parser.
  logic [COUNT_W-1:0] kept;
  logic [7:0]         c0;
  logic [7:0]         c1;
  logic [7:0]         c2;
  bit                 ended;
  bit                 comma;
  num_phase_t         phase;
  bit                 neg;
  logic [31:0]        accum;

  result_t pending_cmds[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void clear_line();
    kept  = '0;
    c0    = CH_NUL;
    c1    = CH_NUL;
    c2    = CH_NUL;
    ended = 1'b0;
    comma = 1'b0;
    phase = NUM_SKIP;
    neg   = 1'b0;
    accum = '0;
  endfunction

  function automatic result_t decode_command();
    result_t     r;
    logic [31:0] num;
    logic [7:0]  idx;
    r.action      = ACT_UNKNOWN;
    r.motor_index = '0;
    r.value       = '0;
    r.reverse     = 1'b0;
    num = neg ? (32'd0 - accum) : accum;
    // The index wraps within a byte, so anything below '0' is a bad index too.
    idx = c1 - CH_ZERO;
    if (c0 == CH_P && c1 == CH_NUL) begin
      r.action = ACT_PING;
    end else if (c0 == CH_QUERY) begin
      r.action = ACT_STATUS;
    end else if (c0 == CH_D && c1 == CH_A) begin
      r.action = ACT_DISABLE_ALL;
    end else if (c0 == CH_D && c1 == CH_B && c2 == CH_G) begin
      r.action = ACT_DEBUG;
    end else if (idx >= MOTORS) begin
      r.action = ACT_BAD_INDEX;
    end else begin
      r.motor_index = idx[3:0];
      case (c0)
        CH_E: r.action = ACT_ENABLE;
        CH_D: r.action = ACT_DISABLE;
        CH_S: begin
          if (comma) begin
            r.action = ACT_DUTY;
            r.value  = num;
          end else begin
            r.action = ACT_NO_COMMA;
          end
        end
        CH_R: begin
          if (comma) begin
            r.action  = ACT_DIR;
            r.value   = num;
            r.reverse = (num != 32'd0);
          end else begin
            r.action = ACT_NO_COMMA;
          end
        end
        CH_C: r.action = ACT_CLEAR_FAULT;
        CH_Z: r.action = ACT_ZERO_COUNT;
        default: begin
          r.action      = ACT_UNKNOWN;
          r.motor_index = '0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [COUNT_W-1:0] pos;
    bit                 digit;
    bit                 blank;
    if (b == CH_LF || b == CH_CR) begin
      if (kept != '0) begin
        pending_cmds.push_back(decode_command());
        clear_line();
      end
    end else if (kept < LINE_MAX) begin
      pos  = kept;
      kept = kept + 1'b1;
      if (pos == 0) c0 = b;
      else if (pos == 1) c1 = b;
      else if (pos == 2) c2 = b;
      if (pos >= 2 && !ended) begin
        digit = (b >= CH_ZERO && b <= CH_NINE);
        blank = (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
        if (b == CH_NUL) begin
          ended = 1'b1;
        end else if (!comma) begin
          comma = (b == CH_COMMA);
        end else if (phase == NUM_SKIP && blank) begin
          // Leading whitespace before the number is skipped.
        end else if (phase == NUM_SKIP && (b == CH_PLUS || b == CH_MINUS)) begin
          neg   = (b == CH_MINUS);
          phase = NUM_ACTIVE;
        end else if (phase != NUM_DONE && digit) begin
          accum = accum * 32'd10 + 32'(b - CH_ZERO);
          phase = NUM_ACTIVE;
        end else begin
          phase = NUM_DONE;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_line();
      pending_cmds.delete();
    end else begin
      // A result is registered after its line end, so the
      // output side is checked before the byte of this cycle is parsed.
      if (m_tvalid && m_tready) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected result transaction, data %h", m_tdata);
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          if (m_tdata[3:0] != want.action) begin
            $error("action: expected %0d, actual %0d", want.action, m_tdata[3:0]);
            mismatches++;
          end
          if (m_tdata[7:4] != want.motor_index) begin
            $error("motor_index: expected %0d, actual %0d", want.motor_index,
                   m_tdata[7:4]);
            mismatches++;
          end
          if (m_tdata[39:8] != want.value) begin
            $error("value: expected %0d, actual %0d", want.value, m_tdata[39:8]);
            mismatches++;
          end
          if (m_tdata[40] != want.reverse) begin
            $error("reverse: expected %0d, actual %0d", want.reverse, m_tdata[40]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) parse_byte(s_tdata);
    end
    outstanding = pending_cmds.size();
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the ASCII motor command parser. A directed set of lines covers
// every command, the error cases, zero bytes, number wrap and an overlong
// line; random lines follow, mostly well-formed commands with random content
// plus noise. Both channels stall in random bursts. The checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import amcp_pkg::*;

  localparam int RANDOM_BYTES = 1225;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [7:0] CMD_LETTERS [8] = '{CH_E, CH_D, CH_S, CH_R, CH_C, CH_Z,
                                             CH_P, CH_A};
  localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, 8'h0B, 8'h0C};

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [7:0]       s_tdata  = 8'h00;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int sent_bytes  = 0;
  int cycles      = 0;
  int stall_pct   = 0;
  int stall_left  = 0;
  bit quiet       = 1'b0;
  bit sender_gaps = 1'b0;
  int random_end;

  always #2 clk = ~clk;

  ascii_motor_command_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  command_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: ready drops in bursts of random length.
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Valid stays high from one byte to the next unless a gap is inserted.
  task automatic send_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    send_text(s);
    send_byte(term);
  endtask

  // Holds the byte stream until every decoded command has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic send_random_line();
    logic [7:0] text[$];
    int         pick;
    int         sign;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      text.push_back(CH_P);
    end else if (pick == 1) begin
      text.push_back(CH_QUERY);
    end else if (pick == 2) begin
      text.push_back(CH_D);
      text.push_back(CH_A);
    end else if (pick == 3) begin
      text.push_back(CH_D);
      text.push_back(CH_B);
      text.push_back(CH_G);
    end else if (pick <= 5) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      text.push_back(CMD_LETTERS[$urandom_range(0, 7)]);
      case ($urandom_range(0, 7))
        6:       text.push_back(8'(CH_ZERO + $urandom_range(MOTORS, 9)));
        7:       text.push_back(8'($urandom_range(0, 255)));
        default: text.push_back(8'(CH_ZERO + $urandom_range(0, MOTORS - 1)));
      endcase
      if ($urandom_range(0, 5) != 0) text.push_back(CH_COMMA);
      repeat ($urandom_range(0, 2)) text.push_back(BLANKS[$urandom_range(0, 3)]);
      sign = $urandom_range(0, 5);
      if (sign == 1) text.push_back(CH_PLUS);
      if (sign == 2 || sign == 3) text.push_back(CH_MINUS);
      if (sign == 3) text.push_back(CH_PLUS);
      // Long digit strings can make the value wrap.
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(8, 14) : $urandom_range(0, 4))
        text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      if ($urandom_range(0, 4) == 0) begin
        text.push_back(8'($urandom_range(CH_SPACE, 8'h7E)));
        text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    end
    if ($urandom_range(0, 19) == 0) text.insert($urandom_range(0, text.size()), CH_NUL);
    if ($urandom_range(0, 24) == 0)
      repeat ($urandom_range(50, 70)) text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    foreach (text[i]) send_byte(text[i]);
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    if ($urandom_range(0, 7) == 0) send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    sender_gaps = 1'b1;
    stall_pct  <= 30;
    send_line("P", CH_LF);
    send_line("?", CH_CR);
    send_line("DA", CH_LF);
    send_line("DBG", CH_LF);
    send_line("E0", CH_CR);
    send_line("D2", CH_LF);
    send_line("S1,100", CH_LF);
    send_line("R0,-5", CH_CR);
    send_line("R2,0", CH_LF);
    send_line("C1", CH_LF);
    send_line("Z0", CH_LF);
    send_line("E3", CH_LF);
    send_line("E/", CH_LF);
    send_line("S1", CH_LF);
    send_line("X0", CH_LF);
    send_line("S0, \t+4294967301", CH_LF);
    send_line("S1,4294967295", CH_CR);
    send_line("R1,-", CH_LF);
    // A second line end on an empty line decodes nothing.
    send_byte(CH_CR);
    // Ping with an explicit zero as its second byte.
    send_byte(CH_P);
    send_byte(CH_NUL);
    send_byte(CH_LF);
    // A zero byte at position 2 hides the comma that follows.
    send_text("S1");
    send_byte(CH_NUL);
    send_line(",5", CH_LF);
    // Overlong line: only the first LINE_MAX bytes count.
    send_text("R2,");
    repeat (70) send_byte(CH_NINE);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_line("0", CH_LF);
    drain();

    random_end = sent_bytes + RANDOM_BYTES;
    while (sent_bytes < random_end) begin
      if (sent_bytes > random_end - RANDOM_BYTES / 8) quiet <= 1'b1;
      sender_gaps = !quiet && $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 2))
        0:       stall_pct <= 0;
        1:       stall_pct <= 10;
        default: stall_pct <= 40;
      endcase
      send_random_line();
      if ($urandom_range(0, 39) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/amcp_pkg.sv
rtl/amcp_decode.sv
rtl/amcp_out_buf.sv
rtl/ascii_motor_command_parser.sv
dv/command_checker.sv
dv/tb.sv
